// ----- src/fsba_pkg.sv -----
package fsba_pkg;

  // fixed field widths
  localparam int SIZE_W = 20;
  localparam int ADDR_W = 20;
  localparam int LEN_W  = 20;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_NULL      = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // placement rules; the spare code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

endpackage

// ----- src/fsba_table.sv -----
module fsba_table #(
  parameter int ENTRIES = 16,
  parameter int AW      = 20,
  localparam int IW     = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [IW-1:0]              rd_idx,
  output logic [AW-1:0]              rd_base,
  output logic [fsba_pkg::LEN_W-1:0] rd_len,
  input  logic                       wr_en,
  input  logic [IW-1:0]              wr_idx,
  input  logic [AW-1:0]              wr_base,
  input  logic [fsba_pkg::LEN_W-1:0] wr_len
);

  logic [AW-1:0]              base_mem [ENTRIES];
  logic [fsba_pkg::LEN_W-1:0] len_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      base_mem[wr_idx] <= wr_base;
      len_mem[wr_idx]  <= wr_len;
    end
    if (rd_en) begin
      rd_base <= base_mem[rd_idx];
      rd_len  <= len_mem[rd_idx];
    end
  end

endmodule

// ----- src/fit_strategy_block_allocator_unit.sv -----
// timing: a request rejected at once (zero size, null free, used table full) has its result
//   registered in the cycle after acceptance; otherwise the scan reads the active table one
//   entry at a time until a match or the end, then the pick state, then, when a table entry is
//   taken out, the shift state that moves the later entries down and the append state
// flow: one item at a time; the next item is taken once the result is taken and the unit is
//   idle again, set by the single registered read port of each table and the compare unit
// reset: rst_n synchronous active low; both tables empty, heap break zero, first fit
module fit_strategy_block_allocator_unit #(
  parameter int              FREE_ENTRIES = 16,
  parameter int              USED_ENTRIES = 16,
  parameter longint unsigned HEAP_BYTES   = 64'd1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: fit strategy
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // request_size [19:0], free_address [39:20]
  input  logic [1:0]  in_tuser,   // cmd [0], free_is_null [1]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status [2:0], block_address [22:3], zero fill [23]
  output logic        out_tuser   // from_free_table [0]
);

  localparam int LW   = fsba_pkg::LEN_W;
  localparam int SW   = fsba_pkg::SIZE_W;
  // heap offsets and break
  localparam int AW   = $clog2(HEAP_BYTES);
  localparam int BW   = $clog2(HEAP_BYTES + 64'd1);
  localparam int MW   = (AW > fsba_pkg::ADDR_W) ? AW : fsba_pkg::ADDR_W;
  localparam int EW   = ((BW > SW) ? BW : SW) + 1;
  // table indexes and counts
  localparam int FIW  = $clog2(FREE_ENTRIES);
  localparam int UIW  = $clog2(USED_ENTRIES);
  localparam int FCW  = $clog2(FREE_ENTRIES + 1);
  localparam int UCW  = $clog2(USED_ENTRIES + 1);
  localparam int MAXE = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int XW   = $clog2(MAXE + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PICK, S_SHIFT, S_APPEND, S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         fit_r, fit_nxt;
  fsba_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [SW-1:0]      size_r, size_nxt;
  logic [fsba_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [FCW-1:0]     free_cnt_r, free_cnt_nxt;
  logic [UCW-1:0]     used_cnt_r, used_cnt_nxt;
  logic [BW-1:0]      brk_r, brk_nxt;
  logic [XW-1:0]      iss_r, iss_nxt;
  logic               ev_vld_r, ev_vld_nxt;
  logic [XW-1:0]      ev_idx_r, ev_idx_nxt;
  logic               pick_vld_r, pick_vld_nxt;
  logic [XW-1:0]      pick_idx_r, pick_idx_nxt;
  logic [AW-1:0]      pick_base_r, pick_base_nxt;
  logic [LW-1:0]      pick_len_r, pick_len_nxt;
  logic               out_vld_r, out_vld_nxt;
  fsba_pkg::status_t  out_st_r, out_st_nxt;
  logic [fsba_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic               out_from_r, out_from_nxt;

  // table ports
  logic           f_rd_en, f_wr_en, u_rd_en, u_wr_en;
  logic [FIW-1:0] f_rd_idx, f_wr_idx;
  logic [UIW-1:0] u_rd_idx, u_wr_idx;
  logic [AW-1:0]  f_rd_base, f_wr_base, u_rd_base, u_wr_base;
  logic [LW-1:0]  f_rd_len, f_wr_len, u_rd_len, u_wr_len;

  // active table: freed blocks for allocate, blocks in use for free
  logic [XW-1:0]  cnt_act;
  logic [AW-1:0]  act_base;
  logic [LW-1:0]  act_len;
  logic           issue;
  logic           fits, exact, better;
  logic [EW-1:0]  brk_sum;
  logic [XW-1:0]  wr_back;
  logic           in_acc;

  fsba_table #(.ENTRIES(FREE_ENTRIES), .AW(AW)) u_free_tbl (
    .clk(clk), .rd_en(f_rd_en), .rd_idx(f_rd_idx), .rd_base(f_rd_base), .rd_len(f_rd_len),
    .wr_en(f_wr_en), .wr_idx(f_wr_idx), .wr_base(f_wr_base), .wr_len(f_wr_len)
  );

  fsba_table #(.ENTRIES(USED_ENTRIES), .AW(AW)) u_used_tbl (
    .clk(clk), .rd_en(u_rd_en), .rd_idx(u_rd_idx), .rd_base(u_rd_base), .rd_len(u_rd_len),
    .wr_en(u_wr_en), .wr_idx(u_wr_idx), .wr_base(u_wr_base), .wr_len(u_wr_len)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_addr_r, out_st_r};
  assign out_tuser  = out_from_r;

  assign cnt_act  = (cmd_r == fsba_pkg::CMD_FREE) ? XW'(used_cnt_r) : XW'(free_cnt_r);
  assign act_base = (cmd_r == fsba_pkg::CMD_FREE) ? u_rd_base : f_rd_base;
  assign act_len  = (cmd_r == fsba_pkg::CMD_FREE) ? u_rd_len : f_rd_len;
  assign wr_back  = ev_idx_r - XW'(1);

  // the shared compare unit
  assign fits    = act_len >= size_r;
  assign exact   = act_len == size_r;
  assign better  = (fit_r == fsba_pkg::FIT_WORST) ? (act_len > pick_len_r)
                                                  : (act_len < pick_len_r);
  assign brk_sum = EW'(brk_r) + EW'(size_r);

  always_comb begin
    state_nxt     = state_r;
    fit_nxt       = cfg_we ? cfg_wdata : fit_r;
    cmd_nxt       = cmd_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    free_cnt_nxt  = free_cnt_r;
    used_cnt_nxt  = used_cnt_r;
    brk_nxt       = brk_r;
    iss_nxt       = iss_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = iss_r;
    pick_vld_nxt  = pick_vld_r;
    pick_idx_nxt  = pick_idx_r;
    pick_base_nxt = pick_base_r;
    pick_len_nxt  = pick_len_r;
    out_vld_nxt   = out_vld_r;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;
    out_from_nxt  = out_from_r;
    issue         = 1'b0;
    f_rd_en = 1'b0; f_wr_en = 1'b0; u_rd_en = 1'b0; u_wr_en = 1'b0;
    f_rd_idx  = iss_r[FIW-1:0];
    u_rd_idx  = iss_r[UIW-1:0];
    f_wr_idx  = wr_back[FIW-1:0];
    u_wr_idx  = wr_back[UIW-1:0];
    f_wr_base = act_base;
    f_wr_len  = act_len;
    u_wr_base = act_base;
    u_wr_len  = act_len;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = fsba_pkg::cmd_t'(in_tuser[0]);
          size_nxt     = in_tdata[19:0];
          addr_nxt     = in_tdata[39:20];
          out_addr_nxt = '0;
          out_from_nxt = 1'b0;
          iss_nxt      = '0;
          pick_vld_nxt = 1'b0;
          pick_len_nxt = '0;
          state_nxt    = S_SCAN;
          if (in_tuser[0] == fsba_pkg::CMD_ALLOC) begin
            if (in_tdata[19:0] == '0) begin
              out_st_nxt = fsba_pkg::ST_ZERO;
              state_nxt  = S_RESP;
              out_vld_nxt = 1'b1;
            end else if (used_cnt_r == UCW'(USED_ENTRIES)) begin
              out_st_nxt = fsba_pkg::ST_FULL;
              state_nxt  = S_RESP;
              out_vld_nxt = 1'b1;
            end
          end else if (in_tuser[1]) begin
            out_st_nxt  = fsba_pkg::ST_NULL;
            state_nxt   = S_RESP;
            out_vld_nxt = 1'b1;
          end
        end
      end

      // one read issued per cycle, the entry read last cycle compared
      S_SCAN: begin
        issue = iss_r < cnt_act;
        if (ev_vld_r) begin
          if (cmd_r == fsba_pkg::CMD_FREE) begin
            if (MW'(act_base) == MW'(addr_r)) begin
              pick_vld_nxt = 1'b1;
              pick_idx_nxt = ev_idx_r;
              pick_base_nxt = act_base;
              pick_len_nxt = act_len;
              issue = 1'b0;
              state_nxt = S_PICK;
            end
          end else if (fits) begin
            if ((fit_r == fsba_pkg::FIT_BEST && exact) ||
                (fit_r != fsba_pkg::FIT_BEST && fit_r != fsba_pkg::FIT_WORST)) begin
              pick_vld_nxt = 1'b1;
              pick_idx_nxt = ev_idx_r;
              pick_base_nxt = act_base;
              pick_len_nxt = act_len;
              issue = 1'b0;
              state_nxt = S_PICK;
            end else if (!pick_vld_r || better) begin
              pick_vld_nxt = 1'b1;
              pick_idx_nxt = ev_idx_r;
              pick_base_nxt = act_base;
              pick_len_nxt = act_len;
            end
          end
        end
        if (!ev_vld_r && !issue) begin
          state_nxt = S_PICK;
        end
        if (issue) begin
          f_rd_en    = (cmd_r == fsba_pkg::CMD_ALLOC);
          u_rd_en    = (cmd_r == fsba_pkg::CMD_FREE);
          iss_nxt    = iss_r + XW'(1);
          ev_vld_nxt = 1'b1;
        end
      end

      S_PICK: begin
        iss_nxt   = pick_idx_r + XW'(1);
        state_nxt = S_RESP;
        if (cmd_r == fsba_pkg::CMD_ALLOC) begin
          if (pick_vld_r) begin
            state_nxt = S_SHIFT;
          end else if (brk_sum > EW'(HEAP_BYTES)) begin
            out_st_nxt = fsba_pkg::ST_EXHAUSTED;
          end else begin
            // bump the break
            u_wr_en      = 1'b1;
            u_wr_idx     = used_cnt_r[UIW-1:0];
            u_wr_base    = AW'(brk_r);
            u_wr_len     = size_r;
            used_cnt_nxt = used_cnt_r + UCW'(1);
            brk_nxt      = BW'(brk_sum);
            out_addr_nxt = fsba_pkg::ADDR_W'(MW'(brk_r));
            out_st_nxt   = fsba_pkg::ST_OK;
          end
        end else if (!pick_vld_r) begin
          out_st_nxt = fsba_pkg::ST_UNKNOWN;
        end else if (free_cnt_r == FCW'(FREE_ENTRIES)) begin
          out_st_nxt = fsba_pkg::ST_FULL;
        end else begin
          f_wr_en      = 1'b1;
          f_wr_idx     = free_cnt_r[FIW-1:0];
          f_wr_base    = pick_base_r;
          f_wr_len     = pick_len_r;
          free_cnt_nxt = free_cnt_r + FCW'(1);
          state_nxt    = S_SHIFT;
        end
        out_vld_nxt = (state_nxt == S_RESP);
      end

      // close the gap: read entry j, write it back at j - 1
      S_SHIFT: begin
        issue = iss_r < cnt_act;
        if (ev_vld_r) begin
          f_wr_en = (cmd_r == fsba_pkg::CMD_ALLOC);
          u_wr_en = (cmd_r == fsba_pkg::CMD_FREE);
        end
        if (issue) begin
          f_rd_en    = (cmd_r == fsba_pkg::CMD_ALLOC);
          u_rd_en    = (cmd_r == fsba_pkg::CMD_FREE);
          iss_nxt    = iss_r + XW'(1);
          ev_vld_nxt = 1'b1;
        end else if (!ev_vld_r) begin
          state_nxt = S_APPEND;
        end
      end

      S_APPEND: begin
        out_st_nxt  = fsba_pkg::ST_OK;
        out_vld_nxt = 1'b1;
        state_nxt   = S_RESP;
        if (cmd_r == fsba_pkg::CMD_ALLOC) begin
          if (pick_len_r > size_r) begin
            // remainder of the split goes to the tail
            f_wr_en   = 1'b1;
            f_wr_idx  = FIW'(free_cnt_r - FCW'(1));
            f_wr_base = AW'(MW'(pick_base_r) + MW'(size_r));
            f_wr_len  = pick_len_r - size_r;
          end else begin
            free_cnt_nxt = free_cnt_r - FCW'(1);
          end
          u_wr_en      = 1'b1;
          u_wr_idx     = used_cnt_r[UIW-1:0];
          u_wr_base    = pick_base_r;
          u_wr_len     = size_r;
          used_cnt_nxt = used_cnt_r + UCW'(1);
          out_addr_nxt = fsba_pkg::ADDR_W'(MW'(pick_base_r));
          out_from_nxt = 1'b1;
        end else begin
          used_cnt_nxt = used_cnt_r - UCW'(1);
        end
      end

      S_RESP: begin
        if (out_tready) begin
          out_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fit_r      <= fsba_pkg::FIT_FIRST;
      free_cnt_r <= '0;
      used_cnt_r <= '0;
      brk_r      <= '0;
      ev_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fit_r      <= fit_nxt;
      free_cnt_r <= free_cnt_nxt;
      used_cnt_r <= used_cnt_nxt;
      brk_r      <= brk_nxt;
      ev_vld_r   <= ev_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    cmd_r       <= cmd_nxt;
    size_r      <= size_nxt;
    addr_r      <= addr_nxt;
    iss_r       <= iss_nxt;
    ev_idx_r    <= ev_idx_nxt;
    pick_vld_r  <= pick_vld_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_base_r <= pick_base_nxt;
    pick_len_r  <= pick_len_nxt;
    out_st_r    <= out_st_nxt;
    out_addr_r  <= out_addr_nxt;
    out_from_r  <= out_from_nxt;
  end

  // table fill never runs past its depth
  a_used_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= UCW'(USED_ENTRIES)) else $error("used count overflow");

  a_free_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FCW'(FREE_ENTRIES)) else $error("free count overflow");

  // the break stays inside the heap
  a_brk: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(brk_r) <= EW'(HEAP_BYTES)) else $error("heap break past heap end");

  // a reused block is only ever reported with an ok status
  a_reuse_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_from_r |-> out_st_r == fsba_pkg::ST_OK)
    else $error("reuse flag on failed request");

  // an item closes the input until its result is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("input reopened during request");

endmodule
